// ===== hw/rtl/hpf_pkg.sv =====
`timescale 1ns / 1ps

package hpf_pkg;

  // Width of the running byte position.
  localparam int OFFSET_BITS = 32;

  // Width used when a record length is worked out, wide enough to see saturation.
  localparam int LEN_CALC_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 33;

  localparam int TIME_W = 48;
  localparam int TICKS_W = 32;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 32'd1000;

  // Top 22 bits of the window that mark a picture start code.
  localparam logic [21:0] PSC_CODE = 22'h000020;
  localparam logic [31:0] WINDOW_RESET = 32'hffff_ffff;
  localparam logic [31:0] LEN_MAX = 32'hffff_ffff;

  // Record kinds.
  localparam logic KIND_PICTURE = 1'b0;
  localparam logic KIND_LEADING = 1'b1;

  // Source formats that carry a picture size.
  localparam logic [2:0] FMT_SUBQCIF = 3'd1;
  localparam logic [2:0] FMT_QCIF = 3'd2;
  localparam logic [2:0] FMT_CIF = 3'd3;
  localparam logic [2:0] FMT_4CIF = 3'd4;
  localparam logic [2:0] FMT_16CIF = 3'd5;

  // Depth of the queue between the scanner and the output stage.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One record as the scanner describes it.
  typedef struct packed {
    logic                   leading;
    logic [OFFSET_BITS-1:0] first_pos;
    logic [OFFSET_BITS-1:0] end_pos;
    logic [2:0]             fmt;
    logic                   intra;
    logic [TIME_W-1:0]      ts;
  } rec_t;

  // Everything one stream byte causes: a record closed by a start code,
  // and a record flushed by end of stream.
  typedef struct packed {
    logic a_valid;
    logic b_valid;
    rec_t rec_a;
    rec_t rec_b;
  } step_t;

  // Picture width for a source format; the 16CIF entry is 1408, not 1409.
  function automatic logic [10:0] fmt_width(input logic [2:0] fmt);
    logic [10:0] w;
    unique case (fmt)
      FMT_SUBQCIF: w = 11'd128;
      FMT_QCIF:    w = 11'd176;
      FMT_CIF:     w = 11'd352;
      FMT_4CIF:    w = 11'd704;
      FMT_16CIF:   w = 11'd1408;
      default:     w = 11'd0;
    endcase
    return w;
  endfunction

  // Picture height for a source format.
  function automatic logic [10:0] fmt_height(input logic [2:0] fmt);
    logic [10:0] h;
    unique case (fmt)
      FMT_SUBQCIF: h = 11'd96;
      FMT_QCIF:    h = 11'd144;
      FMT_CIF:     h = 11'd288;
      FMT_4CIF:    h = 11'd576;
      FMT_16CIF:   h = 11'd1152;
      default:     h = 11'd0;
    endcase
    return h;
  endfunction

endpackage

// ===== hw/rtl/h263_picture_framer.sv =====
`timescale 1ns / 1ps

// H.263 picture framer. The block scans an elementary stream one byte per
// cycle, finds picture start codes, and sends one request per record: the
// data before the first start code, then each picture with its offset,
// length, source format, size, intra flag and timestamp. A byte flagged as
// end of stream flushes the open record and returns the scanner to its reset
// state; the timestamp increment register keeps its value. The scanner takes
// a byte in every cycle while the two-entry step queue has room. The output
// stage sends one record per cycle while out_ready is high, so a byte that both
// closes a picture and ends the stream gives it two records to send. The queue
// absorbs the extra record unless the next byte also closes or flushes a record,
// in which case the byte after that one waits. Write the increment register only
// while no byte is in flight.

module h263_picture_framer
  import hpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_stream_byte,
  input  logic               in_end_of_stream,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_record_kind,
  output logic [31:0]        out_record_offset,
  output logic [31:0]        out_byte_length,
  output logic [2:0]         out_source_format,
  output logic [10:0]        out_pixel_width,
  output logic [10:0]        out_pixel_height,
  output logic               out_is_intra,
  output logic [TIME_W-1:0]  out_timestamp,
  output logic               out_ended_by_stream_end,
  output logic               out_last_of_run,
  input  logic               cfg_wr_en,
  input  logic [TICKS_W-1:0] cfg_wr_data
);

  logic  push_valid;
  logic  push_ready;
  step_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  step_t pop_data;

  // Byte scanner.
  hpf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .in_end_of_stream (in_end_of_stream),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .push_ready       (push_ready),
    .push_valid       (push_valid),
    .push_data        (push_data)
  );

  // Step queue between scanner and output stage.
  hpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Record formatter and output register.
  hpf_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .pop_valid               (pop_valid),
    .pop_ready               (pop_ready),
    .pop_data                (pop_data),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_record_kind         (out_record_kind),
    .out_record_offset       (out_record_offset),
    .out_byte_length         (out_byte_length),
    .out_source_format       (out_source_format),
    .out_pixel_width         (out_pixel_width),
    .out_pixel_height        (out_pixel_height),
    .out_is_intra            (out_is_intra),
    .out_timestamp           (out_timestamp),
    .out_ended_by_stream_end (out_ended_by_stream_end),
    .out_last_of_run         (out_last_of_run)
  );

endmodule

// ===== hw/rtl/hpf_front.sv =====
`timescale 1ns / 1ps

module hpf_front
  import hpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_stream_byte,
  input  logic                 in_end_of_stream,
  input  logic                 cfg_wr_en,
  input  logic [TICKS_W-1:0]   cfg_wr_data,
  input  logic                 push_ready,
  output logic                 push_valid,
  output step_t                push_data
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] POS_THREE = OFFSET_BITS'(3);

  logic [TICKS_W-1:0]     ticks_r;
  logic [31:0]            window_r, window_nxt;
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic                   open_r, open_nxt;
  logic [OFFSET_BITS-1:0] pstart_r, pstart_nxt;
  logic [2:0]             fmt_r, fmt_nxt;
  logic                   inter_r, inter_nxt;
  logic                   pending_r, pending_nxt;
  logic [TIME_W-1:0]      time_r, time_nxt;

  logic                   accept;
  logic [OFFSET_BITS-1:0] seen_inc;
  logic [OFFSET_BITS-1:0] code_start;
  logic                   start_code;
  logic [2:0]             fmt_cur;
  logic                   inter_cur;
  logic                   pending_cur;
  logic [TIME_W-1:0]      time_adv;
  step_t                  step;

  assign accept = in_valid && in_ready;
  assign in_ready = push_ready;

  // Timestamp increment register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
    end else if (cfg_wr_en) begin
      ticks_r <= cfg_wr_data;
    end
  end

  // Scan one byte: header capture, start code test and end-of-stream flush.
  always_comb begin
    window_nxt = {window_r[23:0], in_stream_byte};
    seen_inc = (seen_r == POS_MAX) ? seen_r : seen_r + OFFSET_BITS'(1);
    code_start = (seen_r >= POS_THREE) ? seen_r - POS_THREE : '0;
    start_code = (window_nxt[31:10] == PSC_CODE);
    time_adv = time_r + TIME_W'(ticks_r);

    // The header byte is taken before the start code test.
    if (pending_r) begin
      fmt_cur = in_stream_byte[4:2];
      inter_cur = in_stream_byte[1];
      pending_cur = 1'b0;
    end else begin
      fmt_cur = fmt_r;
      inter_cur = inter_r;
      pending_cur = pending_r;
    end

    // Record closed by a start code.
    step.a_valid = start_code && (open_r || (code_start != '0));
    step.rec_a.leading = open_r ? KIND_PICTURE : KIND_LEADING;
    step.rec_a.first_pos = open_r ? pstart_r : '0;
    step.rec_a.end_pos = code_start;
    step.rec_a.fmt = (open_r && !pending_cur) ? fmt_cur : 3'd0;
    step.rec_a.intra = open_r && !pending_cur && !inter_cur;
    step.rec_a.ts = time_r;

    open_nxt = open_r;
    pstart_nxt = pstart_r;
    fmt_nxt = fmt_cur;
    inter_nxt = inter_cur;
    pending_nxt = pending_cur;
    time_nxt = step.a_valid ? time_adv : time_r;
    if (start_code) begin
      open_nxt = 1'b1;
      pstart_nxt = code_start;
      fmt_nxt = 3'd0;
      inter_nxt = 1'b0;
      pending_nxt = 1'b1;
    end

    // Record flushed by end of stream, seen after the start code update.
    step.b_valid = in_end_of_stream;
    step.rec_b.leading = open_nxt ? KIND_PICTURE : KIND_LEADING;
    step.rec_b.first_pos = open_nxt ? pstart_nxt : '0;
    step.rec_b.end_pos = seen_inc;
    step.rec_b.fmt = (open_nxt && !pending_nxt) ? fmt_nxt : 3'd0;
    step.rec_b.intra = open_nxt && !pending_nxt && !inter_nxt;
    step.rec_b.ts = time_nxt;

    seen_nxt = seen_inc;
    if (in_end_of_stream) begin
      window_nxt = WINDOW_RESET;
      seen_nxt = '0;
      open_nxt = 1'b0;
      pstart_nxt = '0;
      fmt_nxt = 3'd0;
      inter_nxt = 1'b0;
      pending_nxt = 1'b0;
      time_nxt = '0;
    end
  end

  assign push_valid = accept && (step.a_valid || step.b_valid);
  assign push_data = step;

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      seen_r <= '0;
      open_r <= 1'b0;
      pstart_r <= '0;
      fmt_r <= 3'd0;
      inter_r <= 1'b0;
      pending_r <= 1'b0;
      time_r <= '0;
    end else if (accept) begin
      window_r <= window_nxt;
      seen_r <= seen_nxt;
      open_r <= open_nxt;
      pstart_r <= pstart_nxt;
      fmt_r <= fmt_nxt;
      inter_r <= inter_nxt;
      pending_r <= pending_nxt;
      time_r <= time_nxt;
    end
  end

endmodule

// ===== hw/rtl/hpf_queue.sv =====
`timescale 1ns / 1ps

module hpf_queue
  import hpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  step_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output step_t pop_data
);

  step_t             entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data = entries_r[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // Pointer and fill count update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    count_nxt = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/hpf_back.sv =====
`timescale 1ns / 1ps

module hpf_back
  import hpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  step_t             pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_record_kind,
  output logic [31:0]       out_record_offset,
  output logic [31:0]       out_byte_length,
  output logic [2:0]        out_source_format,
  output logic [10:0]       out_pixel_width,
  output logic [10:0]       out_pixel_height,
  output logic              out_is_intra,
  output logic [TIME_W-1:0] out_timestamp,
  output logic              out_ended_by_stream_end,
  output logic              out_last_of_run
);

  localparam logic [LEN_CALC_W-1:0] LEN_MAX_W = LEN_CALC_W'(LEN_MAX);

  logic                  out_valid_r, out_valid_nxt;
  logic                  a_done_r, a_done_nxt;
  logic                  kind_r;
  logic [31:0]           offset_r;
  logic [31:0]           length_r;
  logic [2:0]            fmt_r;
  logic [10:0]           width_r;
  logic [10:0]           height_r;
  logic                  intra_r;
  logic [TIME_W-1:0]     ts_r;
  logic                  by_eos_r;
  logic                  last_r;

  logic                  use_a;
  rec_t                  cur;
  logic                  load;
  logic [LEN_CALC_W-1:0] first_w;
  logic [LEN_CALC_W-1:0] end_w;
  logic [LEN_CALC_W-1:0] diff_w;
  logic [31:0]           length_cur;

  // Pick the start-code record first, then the end-of-stream record.
  always_comb begin
    use_a = pop_data.a_valid && !a_done_r;
    cur = use_a ? pop_data.rec_a : pop_data.rec_b;
    load = pop_valid && (!out_valid_r || out_ready);
    pop_ready = load && !(use_a && pop_data.b_valid);
    a_done_nxt = a_done_r;
    if (load) begin
      a_done_nxt = use_a && pop_data.b_valid;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Record length, zero when the end does not pass the start, saturating.
  always_comb begin
    first_w = LEN_CALC_W'(cur.first_pos);
    end_w = LEN_CALC_W'(cur.end_pos);
    diff_w = (end_w > first_w) ? end_w - first_w : '0;
    length_cur = (diff_w > LEN_MAX_W) ? LEN_MAX : diff_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      a_done_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      a_done_r <= a_done_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= cur.leading;
      offset_r <= 32'(cur.first_pos);
      length_r <= length_cur;
      fmt_r <= cur.fmt;
      width_r <= fmt_width(cur.fmt);
      height_r <= fmt_height(cur.fmt);
      intra_r <= cur.intra;
      ts_r <= cur.ts;
      by_eos_r <= !use_a;
      last_r <= use_a ? !pop_data.b_valid : 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_record_kind = kind_r;
  assign out_record_offset = offset_r;
  assign out_byte_length = length_r;
  assign out_source_format = fmt_r;
  assign out_pixel_width = width_r;
  assign out_pixel_height = height_r;
  assign out_is_intra = intra_r;
  assign out_timestamp = ts_r;
  assign out_ended_by_stream_end = by_eos_r;
  assign out_last_of_run = last_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hpf_pkg::*;

  localparam int USE_PREDICTOR = -1;
  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BYTES = 70;
  localparam int CFG_SETTLE = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 2000;
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_UNSIZED = 3'd7;

  // One record as it leaves the block.
  typedef struct packed {
    logic              kind;
    logic [31:0]       offset;
    logic [31:0]       length;
    logic [2:0]        fmt;
    logic [10:0]       width;
    logic [10:0]       height;
    logic              intra;
    logic [TIME_W-1:0] stamp;
    logic              by_eos;
    logic              last;
  } framer_rec_t;

  // One row of the directed stream, with records typed in where they are obvious.
  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    int          typed_count;
    framer_rec_t rec0;
    framer_rec_t rec1;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_stream_byte = 8'h00;
  logic               in_end_of_stream = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_record_kind;
  logic [31:0]        out_record_offset;
  logic [31:0]        out_byte_length;
  logic [2:0]         out_source_format;
  logic [10:0]        out_pixel_width;
  logic [10:0]        out_pixel_height;
  logic               out_is_intra;
  logic [TIME_W-1:0]  out_timestamp;
  logic               out_ended_by_stream_end;
  logic               out_last_of_run;
  logic               cfg_wr_en = 1'b0;
  logic [TICKS_W-1:0] cfg_wr_data = '0;

  int send_idle_pct = 15;
  int recv_idle_pct = 66;
  int mismatch_count = 0;
  int records_checked = 0;
  int leading_checked = 0;
  int flushed_checked = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  framer_rec_t expected_records[$];
  framer_rec_t step_records[$];
  framer_rec_t want;
  logic [8:0]  stream_q[$];
  stim_row_t   directed_rows [DIRECTED_ROWS];

  logic [10:0] width_by_fmt [0:7] = '{11'd0, 11'd128, 11'd176, 11'd352, 11'd704,
                                      11'd1408, 11'd0, 11'd0};
  logic [10:0] height_by_fmt [0:7] = '{11'd0, 11'd96, 11'd144, 11'd288, 11'd576,
                                       11'd1152, 11'd0, 11'd0};

  // Scanner state as the predictor sees it.
  logic [31:0]            sc_window;
  logic [OFFSET_BITS-1:0] sc_pos;
  logic                   sc_open;
  logic [OFFSET_BITS-1:0] sc_pic_start;
  logic [2:0]             sc_fmt;
  logic                   sc_inter;
  logic                   sc_hdr_pending;
  logic [TIME_W-1:0]      sc_clock;
  logic [TICKS_W-1:0]     sc_ticks;

  h263_picture_framer DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_stream_byte         (in_stream_byte),
    .in_end_of_stream       (in_end_of_stream),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_record_kind        (out_record_kind),
    .out_record_offset      (out_record_offset),
    .out_byte_length        (out_byte_length),
    .out_source_format      (out_source_format),
    .out_pixel_width        (out_pixel_width),
    .out_pixel_height       (out_pixel_height),
    .out_is_intra           (out_is_intra),
    .out_timestamp          (out_timestamp),
    .out_ended_by_stream_end(out_ended_by_stream_end),
    .out_last_of_run        (out_last_of_run),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic framer_rec_t typed_rec(input logic kind, input logic [31:0] offset,
                                            input logic [31:0] length, input logic [2:0] fmt,
                                            input logic [10:0] width, input logic [10:0] height,
                                            input logic intra, input logic [TIME_W-1:0] stamp,
                                            input logic by_eos, input logic last);
    framer_rec_t r;
    r = '{kind, offset, length, fmt, width, height, intra, stamp, by_eos, last};
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic [7:0] data, input logic eos,
                                         input int typed_count, input framer_rec_t rec0,
                                         input framer_rec_t rec1);
    stim_row_t s;
    s.data = data;
    s.eos = eos;
    s.typed_count = typed_count;
    s.rec0 = rec0;
    s.rec1 = rec1;
    return s;
  endfunction

  // Scanner back to its state after reset; the increment is kept.
  function automatic void clear_scan_state();
    sc_window = WINDOW_RESET;
    sc_pos = '0;
    sc_open = 1'b0;
    sc_pic_start = '0;
    sc_fmt = '0;
    sc_inter = 1'b0;
    sc_hdr_pending = 1'b0;
    sc_clock = '0;
  endfunction

  // Builds a record from the current header state and timestamp.
  function automatic framer_rec_t close_record(input logic leading,
                                               input logic [OFFSET_BITS-1:0] first_pos,
                                               input logic [OFFSET_BITS-1:0] stop_pos,
                                               input logic by_eos);
    framer_rec_t r;
    longint unsigned span;
    logic hdr_ok;
    logic [2:0] f;
    span = (stop_pos > first_pos) ? 64'(stop_pos - first_pos) : 64'd0;
    hdr_ok = !leading && !sc_hdr_pending;
    f = hdr_ok ? sc_fmt : FMT_NONE;
    r.kind = leading ? KIND_LEADING : KIND_PICTURE;
    r.offset = 32'(first_pos);
    r.length = (span > 64'(LEN_MAX)) ? LEN_MAX : 32'(span);
    r.fmt = f;
    r.width = width_by_fmt[f];
    r.height = height_by_fmt[f];
    r.intra = hdr_ok && !sc_inter;
    r.stamp = sc_clock;
    r.by_eos = by_eos;
    r.last = 1'b0;
    return r;
  endfunction

  // Predicts the records that one accepted byte causes, into step_records.
  function automatic void scan_byte(input logic [7:0] data, input logic eos);
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] code_start;
    step_records.delete();
    pos = sc_pos;
    sc_window = {sc_window[23:0], data};
    if (sc_pos != '1) sc_pos = sc_pos + OFFSET_BITS'(1);

    // The header byte is taken before the start code test on the same byte.
    if (sc_hdr_pending) begin
      sc_fmt = data[4:2];
      sc_inter = data[1];
      sc_hdr_pending = 1'b0;
    end

    // A start code closes the open picture, or the leading data if there is any.
    if (sc_window[31:10] == PSC_CODE) begin
      code_start = (pos >= 3) ? pos - 3 : '0;
      if (sc_open) begin
        step_records.push_back(close_record(1'b0, sc_pic_start, code_start, 1'b0));
        sc_clock = sc_clock + {16'd0, sc_ticks};
      end else if (code_start != '0) begin
        step_records.push_back(close_record(1'b1, '0, code_start, 1'b0));
        sc_clock = sc_clock + {16'd0, sc_ticks};
      end
      sc_open = 1'b1;
      sc_pic_start = code_start;
      sc_fmt = '0;
      sc_inter = 1'b0;
      sc_hdr_pending = 1'b1;
    end

    // End of stream flushes whatever is open and clears the scanner.
    if (eos) begin
      if (sc_open) step_records.push_back(close_record(1'b0, sc_pic_start, sc_pos, 1'b1));
      else step_records.push_back(close_record(1'b1, '0, sc_pos, 1'b1));
      clear_scan_state();
    end

    if (step_records.size() != 0) step_records[step_records.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Presents one byte request and returns at the edge that accepts it.
  task automatic send_request(input logic [7:0] data, input logic eos);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= data;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // The increment register is written only once the block has gone quiet.
  task automatic write_ticks(input logic [TICKS_W-1:0] value);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sc_ticks = value;
  endtask

  function automatic logic [7:0] payload_byte();
    return ($urandom_range(3, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 0));
  endfunction

  // Mostly well-formed pictures with random content, plus noise, broken codes and end-of-stream bytes.
  task automatic build_stream(input int count);
    int pick;
    int payload_len;
    stream_q.delete();
    while (stream_q.size() < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        stream_q.push_back({1'b0, 8'h00});
        stream_q.push_back({1'b0, 8'h00});
        stream_q.push_back({1'b0, 8'h80 | 8'($urandom_range(3, 0))});
        stream_q.push_back({1'b0, 8'($urandom_range(255, 0))});
        stream_q.push_back({1'b0, 8'($urandom_range(255, 0))});
        payload_len = $urandom_range(6, 0);
        repeat (payload_len) stream_q.push_back({1'b0, payload_byte()});
        if ($urandom_range(99, 0) < 15) stream_q[stream_q.size()-1][8] = 1'b1;
      end else if (pick < 82) begin
        repeat ($urandom_range(4, 1)) stream_q.push_back({1'b0, payload_byte()});
      end else if (pick < 92) begin
        stream_q.push_back({1'b0, 8'h00});
        stream_q.push_back({1'b0, 8'h00});
        stream_q.push_back({1'b0, 8'($urandom_range(255, 132))});
      end else begin
        stream_q.push_back({1'b1, 8'($urandom_range(255, 0))});
      end
    end
  endtask

  // Result side: check each accepted request, then choose the next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $display("%0t: record with nothing expected: kind %0d offset 0x%0h length 0x%0h",
                 $time, out_record_kind, out_record_offset, out_byte_length);
        mismatch_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_kind", 64'(want.kind), 64'(out_record_kind));
        check_field("record_offset", 64'(want.offset), 64'(out_record_offset));
        check_field("byte_length", 64'(want.length), 64'(out_byte_length));
        check_field("source_format", 64'(want.fmt), 64'(out_source_format));
        check_field("pixel_width", 64'(want.width), 64'(out_pixel_width));
        check_field("pixel_height", 64'(want.height), 64'(out_pixel_height));
        check_field("is_intra", 64'(want.intra), 64'(out_is_intra));
        check_field("timestamp", 64'(want.stamp), 64'(out_timestamp));
        check_field("ended_by_stream_end", 64'(want.by_eos), 64'(out_ended_by_stream_end));
        check_field("last_of_run", 64'(want.last), 64'(out_last_of_run));
        records_checked++;
        if (want.kind == KIND_LEADING) leading_checked++;
        if (want.by_eos) flushed_checked++;
      end
    end
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Watchdog: too long without any request moving ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with %0d records outstanding", $time,
               expected_records.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int phase;
    int idx;
    logic [TICKS_W-1:0] phase_ticks [RANDOM_PHASES];

    phase_ticks = '{32'd1, 32'hFFFF_FFFF, 32'($urandom), 32'd0,
                    32'($urandom_range(100, 1)), 32'hFFFF_FFFF};

    // Single-byte stream; a picture closed by a start code and then by end of
    // stream; leading data and a headerless picture flushed by one byte; a
    // picture of an unsized format ended on its header byte.
    directed_rows = '{
      stim_row(8'h55, 1'b1, 1,
               typed_rec(KIND_LEADING, 32'd0, 32'd1, FMT_NONE, 11'd0, 11'd0,
                         1'b0, 48'd0, 1'b1, 1'b1), '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h80, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h14, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'hAA, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h83, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'hFF, 1'b0, 1,
               typed_rec(KIND_PICTURE, 32'd0, 32'd6, FMT_16CIF, 11'd1408, 11'd1152,
                         1'b1, 48'd0, 1'b0, 1'b1), '0),
      stim_row(8'h0A, 1'b1, 1,
               typed_rec(KIND_PICTURE, 32'd6, 32'd5, FMT_QCIF, 11'd176, 11'd144,
                         1'b0, 48'd1000, 1'b1, 1'b1), '0),
      stim_row(8'h12, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h34, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h81, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h7F, 1'b1, 2,
               typed_rec(KIND_LEADING, 32'd0, 32'd2, FMT_NONE, 11'd0, 11'd0,
                         1'b0, 48'd0, 1'b0, 1'b0),
               typed_rec(KIND_PICTURE, 32'd2, 32'd4, FMT_NONE, 11'd0, 11'd0,
                         1'b0, 48'd1000, 1'b1, 1'b1)),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h00, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h82, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h55, 1'b0, USE_PREDICTOR, '0, '0),
      stim_row(8'h1C, 1'b1, 1,
               typed_rec(KIND_PICTURE, 32'd0, 32'd5, FMT_UNSIZED, 11'd0, 11'd0,
                         1'b1, 48'd0, 1'b1, 1'b1), '0)
    };

    sc_ticks = TICKS_RESET;
    clear_scan_state();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed stream, running on the increment left by reset.
    for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
      send_request(directed_rows[idx].data, directed_rows[idx].eos);
      scan_byte(directed_rows[idx].data, directed_rows[idx].eos);
      if (directed_rows[idx].typed_count == USE_PREDICTOR) begin
        foreach (step_records[k]) expected_records.push_back(step_records[k]);
      end else begin
        if (directed_rows[idx].typed_count > 0) expected_records.push_back(directed_rows[idx].rec0);
        if (directed_rows[idx].typed_count > 1) expected_records.push_back(directed_rows[idx].rec1);
      end
    end
    in_valid <= 1'b0;

    // Random phases: each pair of phases uses one idling pattern.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_ticks(phase_ticks[phase]);
      build_stream(PHASE_BYTES);
      foreach (stream_q[k]) begin
        send_request(stream_q[k][7:0], stream_q[k][8]);
        scan_byte(stream_q[k][7:0], stream_q[k][8]);
        foreach (step_records[j]) expected_records.push_back(step_records[j]);
      end
      in_valid <= 1'b0;
    end

    // Drain the remaining records, then allow the output stage to settle.
    while (expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d stream bytes over %0d increment settings.", bytes_sent,
             RANDOM_PHASES + 1);
    $display("Checked %0d records: %0d leading data, %0d flushed at end of stream.",
             records_checked, leading_checked, flushed_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hpf_pkg.sv
hw/rtl/hpf_front.sv
hw/rtl/hpf_queue.sv
hw/rtl/hpf_back.sv
hw/rtl/h263_picture_framer.sv
dv/testbench.sv
